@@ hdl/ndas_pkg.sv @@
// Shared types, codes and a helper function for the note-driven actuator sequencer.
package ndas_pkg;

    // Command codes carried in the input tuser field
    typedef enum logic [2:0] {
        CMD_NOTE_ON  = 3'd0,
        CMD_NOTE_OFF = 3'd1,
        CMD_POS_SET  = 3'd2,
        CMD_PWM_SET  = 3'd3,
        CMD_REINIT   = 3'd4
    } cmd_t;

    // Actuator modes; codes 6 and 7 behave as an idle solenoid
    typedef enum logic [2:0] {
        MODE_SERVO_STRIKE   = 3'd0,
        MODE_SERVO_ALT      = 3'd1,
        MODE_SERVO_SCRATCH  = 3'd2,
        MODE_SERVO_KEYHOLD  = 3'd3,
        MODE_SOL_STRIKE     = 3'd4,
        MODE_SOL_HITHOLD    = 3'd5
    } mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ENABLED      = 3'd0,
        REG_MODE         = 3'd1,
        REG_REST_ANGLE   = 3'd2,
        REG_SECOND_ANGLE = 3'd3,
        REG_SWING        = 3'd4,
        REG_RETURN_DELAY = 3'd5,
        REG_HIT_PWM      = 3'd6,
        REG_HOLD_PWM     = 3'd7
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [9:0] MS_TO_US = 10'd1000;

    // Register file contents
    typedef struct packed {
        logic        enabled;
        logic [2:0]  mode;
        logic [7:0]  rest_angle;
        logic [7:0]  second_angle;
        logic [7:0]  swing;
        logic [15:0] return_delay;
        logic [11:0] hit_pwm;
        logic [11:0] hold_pwm;
    } cfg_t;

    // Registered input transaction plus velocity-derived values
    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] level;
        logic [31:0] now_us;
        logic [7:0]  amp;
        logic [15:0] pulse_ms;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic        drive_valid;
        logic        drive_is_angle;
        logic [11:0] drive_value;
        logic        return_valid;
        logic        return_is_position;
        logic [11:0] return_level;
        logic [31:0] return_due_us;
        logic [3:0]  return_target;
        logic        is_active;
    } result_t;

    // Truncating divide by 127 without a divider; exact for x below 2^18.
    // x = 127*(q0+q1) + r2 with r2 < 254, so one compare finishes it.
    function automatic logic [10:0] div127(input logic [17:0] x);
        logic [10:0] q0;
        logic [11:0] r1;
        logic [4:0]  q1;
        logic [7:0]  r2;
        q0 = x[17:7];
        r1 = {5'd0, x[6:0]} + {1'b0, q0};
        q1 = r1[11:7];
        r2 = {1'b0, r1[6:0]} + {3'd0, q1};
        return q0 + 11'(q1) + ((r2 >= 8'd127) ? 11'd1 : 11'd0);
    endfunction

endpackage

@@ hdl/note_driven_actuator_sequencer.sv @@
// Top level of the note-driven actuator sequencer: ports, register file and wiring.
//
// Drives one servo or solenoid from note-event transactions. Every input
// transaction yields exactly one result transaction; a new transaction can be
// taken every clock cycle unless m_tready stalls, since the work is one pass of
// logic between the input register and the result register. With no backpressure,
// m_tvalid rises at the clock edge after the one that accepted the input
// transaction. Velocity scaling (v*span/127, truncated) is done as the transaction
// enters; the state update, saturation and the return due time now_us plus the
// return delay times 1000 (wrapping at 32 bits) are done in the engine stage.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// and should only change while no transaction is in flight.
module note_driven_actuator_sequencer #(
    parameter int MAX_ANGLE    = 180,
    parameter int MIN_ANGLE    = 0,
    parameter int PWM_FULL     = 4095,
    parameter int PULSE_MIN_MS = 5,
    parameter int PULSE_MAX_MS = 50,
    parameter int UNIT_NUMBER  = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ndas_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ndas_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [55:0]                         s_tdata,  // velocity, level, now_us
    input  logic [2:0]                          s_tuser,  // cmd
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drive_valid, drive_value, return_valid, return_level, return_due_us,
    // return_target, is_active
    output logic [63:0]                         m_tdata,
    output logic [1:0]                          m_tuser   // drive_is_angle, return_is_position
);

    ndas_pkg::cfg_t    cfg_reg, cfg_next;
    ndas_pkg::item_t   item;
    ndas_pkg::result_t result;
    logic              item_valid, item_take;

    // Register file writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                ndas_pkg::REG_ENABLED:      cfg_next.enabled      = cfg_data[0];
                ndas_pkg::REG_MODE:         cfg_next.mode         = cfg_data[2:0];
                ndas_pkg::REG_REST_ANGLE:   cfg_next.rest_angle   = cfg_data[7:0];
                ndas_pkg::REG_SECOND_ANGLE: cfg_next.second_angle = cfg_data[7:0];
                ndas_pkg::REG_SWING:        cfg_next.swing        = cfg_data[7:0];
                ndas_pkg::REG_RETURN_DELAY: cfg_next.return_delay = cfg_data;
                ndas_pkg::REG_HIT_PWM:      cfg_next.hit_pwm      = cfg_data[11:0];
                ndas_pkg::REG_HOLD_PWM:     cfg_next.hold_pwm     = cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled      <= 1'b0;
            cfg_reg.mode         <= 3'd0;
            cfg_reg.rest_angle   <= 8'd90;
            cfg_reg.second_angle <= 8'd90;
            cfg_reg.swing        <= 8'd30;
            cfg_reg.return_delay <= 16'd50;
            cfg_reg.hit_pwm      <= 12'd4095;
            cfg_reg.hold_pwm     <= 12'd1024;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ndas_input_stage #(
        .PULSE_MIN_MS (PULSE_MIN_MS),
        .PULSE_MAX_MS (PULSE_MAX_MS)
    ) u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .swing      (cfg_reg.swing),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .cmd        (s_tuser),
        .velocity   (s_tdata[6:0]),
        .level      (s_tdata[18:7]),
        .now_us     (s_tdata[50:19]),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    ndas_engine #(
        .MAX_ANGLE   (MAX_ANGLE),
        .MIN_ANGLE   (MIN_ANGLE),
        .PWM_FULL    (PWM_FULL),
        .UNIT_NUMBER (UNIT_NUMBER)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .result     (result)
    );

    // Result packing
    assign m_tdata = {1'b0,
                      result.is_active,
                      result.return_target,
                      result.return_due_us,
                      result.return_level,
                      result.return_valid,
                      result.drive_value,
                      result.drive_valid};
    assign m_tuser = {result.return_is_position, result.drive_is_angle};

endmodule

@@ hdl/ndas_input_stage.sv @@
// Input register stage: accepts a transaction and precomputes velocity scaling.
module ndas_input_stage #(
    parameter int PULSE_MIN_MS = 5,
    parameter int PULSE_MAX_MS = 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           swing,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           cmd,
    input  logic [6:0]           velocity,
    input  logic [11:0]          level,
    input  logic [31:0]          now_us,
    output logic                 item_valid,
    input  logic                 item_take,
    output ndas_pkg::item_t      item
);

    localparam int SPAN     = PULSE_MAX_MS - PULSE_MIN_MS;
    localparam int SPAN_ABS = (SPAN < 0) ? -SPAN : SPAN;

    logic            valid_reg, valid_next;
    ndas_pkg::item_t item_reg, item_next;
    logic [17:0]     amp_prod, pulse_prod;
    logic [10:0]     amp_q, pulse_q;
    logic [15:0]     pulse_ms;

    // Velocity scaling: swing amplitude and solenoid pulse length
    always_comb begin
        amp_prod   = 18'({8'd0, velocity} * {7'd0, swing});
        amp_q      = ndas_pkg::div127(amp_prod);
        pulse_prod = 18'(velocity) * 18'(SPAN_ABS);
        pulse_q    = ndas_pkg::div127(pulse_prod);
        if (SPAN < 0) begin
            pulse_ms = 16'(PULSE_MIN_MS) - 16'(pulse_q);
        end else begin
            pulse_ms = 16'(PULSE_MIN_MS) + 16'(pulse_q);
        end
    end

    assign s_ready = !valid_reg || item_take;

    // Next-value logic for the holding register
    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next         = 1'b1;
            item_next.cmd      = cmd;
            item_next.level    = level;
            item_next.now_us   = now_us;
            item_next.amp      = amp_q[7:0];
            item_next.pulse_ms = pulse_ms;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/ndas_engine.sv @@
// Event engine: actuator state, per-transaction decision logic and result register.
module ndas_engine #(
    parameter int MAX_ANGLE   = 180,
    parameter int MIN_ANGLE   = 0,
    parameter int PWM_FULL    = 4095,
    parameter int UNIT_NUMBER = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ndas_pkg::cfg_t       cfg,
    input  logic                 item_valid,
    output logic                 item_take,
    input  ndas_pkg::item_t      item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ndas_pkg::result_t    result
);

    logic              active_reg, active_next;
    logic              alt_reg, alt_next;
    logic              scratch_up_reg, scratch_up_next;
    logic [11:0]       drive_reg, drive_next;
    logic              out_valid_reg, out_valid_next;
    ndas_pkg::result_t res_reg, res_next, res_calc;

    logic              servo, drv, ret;
    logic [11:0]       dval, rlevel;
    logic [15:0]       rdelay;
    logic [25:0]       delay_us;
    logic              on, off, pos, pwm;

    // Clamp to MAX_ANGLE first, then to MIN_ANGLE
    function automatic logic [11:0] sat_angle(input logic signed [10:0] a);
        logic signed [11:0] t;
        t = 12'(a);
        if (t > $signed(12'(MAX_ANGLE))) t = $signed(12'(MAX_ANGLE));
        if (t < $signed(12'(MIN_ANGLE))) t = $signed(12'(MIN_ANGLE));
        return t;
    endfunction

    function automatic logic [11:0] sat_pwm(input logic [11:0] p);
        if ({5'd0, p} > 17'(PWM_FULL)) return 12'(PWM_FULL);
        return p;
    endfunction

    assign item_take = item_valid && (!out_valid_reg || m_ready);

    // Decision logic for the transaction in the input register
    always_comb begin
        servo           = (cfg.mode <= ndas_pkg::MODE_SERVO_KEYHOLD);
        on              = (item.cmd == ndas_pkg::CMD_NOTE_ON);
        off             = (item.cmd == ndas_pkg::CMD_NOTE_OFF);
        pos             = (item.cmd == ndas_pkg::CMD_POS_SET);
        pwm             = (item.cmd == ndas_pkg::CMD_PWM_SET);
        drv             = 1'b0;
        ret             = 1'b0;
        dval            = '0;
        rlevel          = '0;
        rdelay          = '0;
        active_next     = active_reg;
        alt_next        = alt_reg;
        scratch_up_next = scratch_up_reg;

        if (item.cmd == ndas_pkg::CMD_REINIT) begin
            active_next     = 1'b0;
            alt_next        = 1'b0;
            scratch_up_next = 1'b1;
            drv             = 1'b1;
            dval            = servo ? sat_angle(11'(cfg.rest_angle)) : 12'd0;
        end else if (cfg.enabled) begin
            case (cfg.mode)
                ndas_pkg::MODE_SERVO_STRIKE: begin
                    if (on) begin
                        drv         = 1'b1;
                        dval        = sat_angle(11'(cfg.rest_angle) + 11'(item.amp));
                        active_next = 1'b1;
                        ret         = 1'b1;
                        rdelay      = cfg.return_delay;
                        rlevel      = sat_angle(11'(cfg.rest_angle));
                    end else if (pos) begin
                        drv         = 1'b1;
                        dval        = sat_angle(11'(item.level[9:0]) |
                                      ((|item.level[11:10]) ? 11'h3FF : 11'd0));
                        active_next = 1'b0;
                    end
                end
                ndas_pkg::MODE_SERVO_ALT: begin
                    if (on) begin
                        drv         = 1'b1;
                        dval        = sat_angle(11'(alt_reg ? cfg.rest_angle
                                                            : cfg.second_angle));
                        alt_next    = !alt_reg;
                        active_next = 1'b1;
                    end
                end
                ndas_pkg::MODE_SERVO_SCRATCH: begin
                    if (on) begin
                        drv = 1'b1;
                        if (scratch_up_reg) begin
                            dval = sat_angle(11'(cfg.rest_angle) + 11'(item.amp));
                        end else begin
                            dval = sat_angle(11'(cfg.rest_angle) - 11'(item.amp));
                        end
                        scratch_up_next = !scratch_up_reg;
                        active_next     = 1'b1;
                        ret             = 1'b1;
                        rdelay          = cfg.return_delay;
                        rlevel          = sat_angle(11'(cfg.rest_angle));
                    end else if (pos) begin
                        drv         = 1'b1;
                        dval        = sat_angle(11'(item.level[9:0]) |
                                      ((|item.level[11:10]) ? 11'h3FF : 11'd0));
                        active_next = 1'b0;
                    end
                end
                ndas_pkg::MODE_SERVO_KEYHOLD: begin
                    if (on) begin
                        drv         = 1'b1;
                        dval        = sat_angle(11'(cfg.rest_angle) + 11'(cfg.swing));
                        active_next = 1'b1;
                    end else if (off) begin
                        drv         = 1'b1;
                        dval        = sat_angle(11'(cfg.rest_angle));
                        active_next = 1'b0;
                    end
                end
                ndas_pkg::MODE_SOL_STRIKE: begin
                    if (on) begin
                        drv         = 1'b1;
                        dval        = 12'(PWM_FULL);
                        active_next = 1'b1;
                        ret         = 1'b1;
                        rdelay      = item.pulse_ms;
                    end else if (pwm) begin
                        drv         = 1'b1;
                        dval        = sat_pwm(item.level);
                        active_next = 1'b0;
                    end
                end
                ndas_pkg::MODE_SOL_HITHOLD: begin
                    if (on) begin
                        drv         = 1'b1;
                        dval        = sat_pwm(cfg.hit_pwm);
                        active_next = 1'b1;
                        ret         = 1'b1;
                        rdelay      = cfg.return_delay;
                        rlevel      = sat_pwm(cfg.hold_pwm);
                    end else if (pwm) begin
                        drv  = 1'b1;
                        dval = sat_pwm(item.level);
                    end else if (off) begin
                        drv         = 1'b1;
                        active_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        drive_next = drv ? dval : drive_reg;
        delay_us   = 26'(rdelay) * 26'(ndas_pkg::MS_TO_US);

        res_calc.drive_valid        = drv;
        res_calc.drive_is_angle     = servo;
        res_calc.drive_value        = drive_next;
        res_calc.return_valid       = ret;
        res_calc.return_is_position = ret && servo;
        res_calc.return_level       = ret ? rlevel : 12'd0;
        res_calc.return_due_us      = ret ? (item.now_us + 32'(delay_us)) : 32'd0;
        res_calc.return_target      = ret ? 4'(UNIT_NUMBER) : 4'd0;
        res_calc.is_active          = active_next;
    end

    // Output register handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (item_take) begin
            out_valid_next = 1'b1;
            res_next       = res_calc;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            alt_reg        <= 1'b0;
            scratch_up_reg <= 1'b1;
            drive_reg      <= 12'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (item_take) begin
                active_reg     <= active_next;
                alt_reg        <= alt_next;
                scratch_up_reg <= scratch_up_next;
                drive_reg      <= drive_next;
            end
        end
        res_reg <= res_next;
    end

    assign m_valid = out_valid_reg;
    assign result  = res_reg;

`ifndef SYNTHESIS
    // No return request means all return fields are cleared
    a_ret_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !res_reg.return_valid |->
            !res_reg.return_is_position && res_reg.return_level == 12'd0 &&
            res_reg.return_due_us == 32'd0 && res_reg.return_target == 4'd0)
        else $error("return fields set without a return request");

    // Disabled actuator ignores everything but reinit
    a_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && !cfg.enabled && item.cmd != ndas_pkg::CMD_REINIT |=>
            !res_reg.drive_valid && !res_reg.return_valid &&
            res_reg.drive_value == $past(drive_reg))
        else $error("disabled actuator changed its drive");

    // Reinit always drives and leaves the actuator inactive
    a_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && item.cmd == ndas_pkg::CMD_REINIT |=>
            res_reg.drive_valid && !res_reg.is_active && !active_reg &&
            scratch_up_reg && !alt_reg)
        else $error("reinit did not restore initial state");

    // A position return only comes from a servo mode
    a_ret_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.return_is_position |->
            res_reg.return_valid && res_reg.drive_is_angle)
        else $error("position return without servo return request");
`endif

endmodule

@@ tb/note_driven_actuator_sequencer_tb.sv @@
// Self-checking testbench for the note-driven actuator sequencer.
`timescale 1ns / 1ps

module note_driven_actuator_sequencer_tb;

    localparam int ANGLE_MAX = 180;
    localparam int ANGLE_MIN = 0;
    localparam int PWM_TOP   = 4095;
    localparam int PULSE_LO  = 5;
    localparam int PULSE_HI  = 50;
    localparam int UNIT_ID   = 0;

    // command and mode codes beyond the defined ones
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic [2:0] MODE_SPARE_A    = 3'd6;
    localparam logic [2:0] MODE_SPARE_B    = 3'd7;

    localparam int RANDOM_NOTES = 800;
    localparam int QUIET_TAIL   = 100;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 100;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [ndas_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ndas_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;   // velocity, level, now_us
    logic [2:0]  s_tuser   = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // drive_valid, drive_value, return_valid, return_level, return_due_us,
    // return_target, is_active
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;          // drive_is_angle, return_is_position

    note_driven_actuator_sequencer #(
        .MAX_ANGLE    (ANGLE_MAX),
        .MIN_ANGLE    (ANGLE_MIN),
        .PWM_FULL     (PWM_TOP),
        .PULSE_MIN_MS (PULSE_LO),
        .PULSE_MAX_MS (PULSE_HI),
        .UNIT_NUMBER  (UNIT_ID)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // directed stimulus row: a register write or a note event
    typedef struct {
        bit                   is_write;
        ndas_pkg::reg_index_t idx;
        logic [15:0]          wval;
        logic [2:0]           cmd;
        logic [6:0]           vel;
        logic [11:0]          lvl;
        logic [31:0]          now;
        bit                   typed;
        ndas_pkg::result_t    want;
    } stim_row_t;

    stim_row_t         script[$];
    ndas_pkg::result_t awaited_drives[$];
    int        error_count = 0;
    int        idle_odds   = 0;   // chance in 8 of an idle burst, per side
    bit        hold_req    = 1'b0;

    // register shadow
    logic        sh_enabled = 1'b0;
    logic [2:0]  sh_mode    = 3'd0;
    logic [7:0]  sh_rest    = 8'd90;
    logic [7:0]  sh_second  = 8'd90;
    logic [7:0]  sh_swing   = 8'd30;
    logic [15:0] sh_delay   = 16'd50;
    logic [11:0] sh_hit     = 12'd4095;
    logic [11:0] sh_hold    = 12'd1024;

    // actuator state
    logic        act_on     = 1'b0;
    logic        alt_flip   = 1'b0;
    logic        scr_up     = 1'b1;
    logic [11:0] cur_drive  = 12'd0;

    task automatic log_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_error($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
    endtask

    function automatic int clamp_angle(input int a);
        if (a > ANGLE_MAX) a = ANGLE_MAX;
        if (a < ANGLE_MIN) a = ANGLE_MIN;
        return a;
    endfunction

    // Advances the actuator state for one note event and returns its response.
    // PWM levels are 12 bits and so never exceed full scale.
    function automatic ndas_pkg::result_t actuator_response(input logic [2:0] cmd,
            input logic [6:0] vel, input logic [11:0] lvl, input logic [31:0] now);
        ndas_pkg::result_t r;
        logic        servo;
        logic        drv;
        logic        ret;
        int          dval;
        int          rlevel;
        int          amp;
        logic [31:0] rdelay;
        servo  = (sh_mode <= ndas_pkg::MODE_SERVO_KEYHOLD);
        drv    = 1'b0;
        ret    = 1'b0;
        dval   = 0;
        rlevel = 0;
        rdelay = '0;
        amp    = (int'(vel) * int'(sh_swing)) / 127;
        if (cmd == ndas_pkg::CMD_REINIT) begin
            act_on   = 1'b0;
            alt_flip = 1'b0;
            scr_up   = 1'b1;
            cur_drive = 12'd0;
            drv  = 1'b1;
            dval = servo ? clamp_angle(int'(sh_rest)) : 0;
        end else if (sh_enabled) begin
            case (sh_mode)
                ndas_pkg::MODE_SERVO_STRIKE: begin
                    if (cmd == ndas_pkg::CMD_NOTE_ON) begin
                        drv = 1'b1;
                        dval = clamp_angle(int'(sh_rest) + amp);
                        act_on = 1'b1;
                        ret = 1'b1;
                        rdelay = 32'(sh_delay);
                        rlevel = clamp_angle(int'(sh_rest));
                    end else if (cmd == ndas_pkg::CMD_POS_SET) begin
                        drv = 1'b1;
                        dval = clamp_angle(int'(lvl));
                        act_on = 1'b0;
                    end
                end
                ndas_pkg::MODE_SERVO_ALT: begin
                    if (cmd == ndas_pkg::CMD_NOTE_ON) begin
                        drv = 1'b1;
                        dval = clamp_angle(alt_flip ? int'(sh_rest) : int'(sh_second));
                        alt_flip = !alt_flip;
                        act_on = 1'b1;
                    end
                end
                ndas_pkg::MODE_SERVO_SCRATCH: begin
                    if (cmd == ndas_pkg::CMD_NOTE_ON) begin
                        drv = 1'b1;
                        dval = scr_up ? clamp_angle(int'(sh_rest) + amp)
                                      : clamp_angle(int'(sh_rest) - amp);
                        scr_up = !scr_up;
                        act_on = 1'b1;
                        ret = 1'b1;
                        rdelay = 32'(sh_delay);
                        rlevel = clamp_angle(int'(sh_rest));
                    end else if (cmd == ndas_pkg::CMD_POS_SET) begin
                        drv = 1'b1;
                        dval = clamp_angle(int'(lvl));
                        act_on = 1'b0;
                    end
                end
                ndas_pkg::MODE_SERVO_KEYHOLD: begin
                    if (cmd == ndas_pkg::CMD_NOTE_ON) begin
                        drv = 1'b1;
                        dval = clamp_angle(int'(sh_rest) + int'(sh_swing));
                        act_on = 1'b1;
                    end else if (cmd == ndas_pkg::CMD_NOTE_OFF) begin
                        drv = 1'b1;
                        dval = clamp_angle(int'(sh_rest));
                        act_on = 1'b0;
                    end
                end
                ndas_pkg::MODE_SOL_STRIKE: begin
                    if (cmd == ndas_pkg::CMD_NOTE_ON) begin
                        drv = 1'b1;
                        dval = PWM_TOP;
                        act_on = 1'b1;
                        ret = 1'b1;
                        rdelay = 32'(PULSE_LO + (int'(vel) * (PULSE_HI - PULSE_LO)) / 127);
                        rlevel = 0;
                    end else if (cmd == ndas_pkg::CMD_PWM_SET) begin
                        drv = 1'b1;
                        dval = int'(lvl);
                        act_on = 1'b0;
                    end
                end
                ndas_pkg::MODE_SOL_HITHOLD: begin
                    if (cmd == ndas_pkg::CMD_NOTE_ON) begin
                        drv = 1'b1;
                        dval = int'(sh_hit);
                        act_on = 1'b1;
                        ret = 1'b1;
                        rdelay = 32'(sh_delay);
                        rlevel = int'(sh_hold);
                    end else if (cmd == ndas_pkg::CMD_PWM_SET) begin
                        drv = 1'b1;
                        dval = int'(lvl);
                    end else if (cmd == ndas_pkg::CMD_NOTE_OFF) begin
                        drv = 1'b1;
                        dval = 0;
                        act_on = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        if (drv) cur_drive = dval[11:0];
        r.drive_valid        = drv;
        r.drive_is_angle     = servo;
        r.drive_value        = cur_drive;
        r.return_valid       = ret;
        r.return_is_position = ret & servo;
        r.return_level       = ret ? rlevel[11:0] : 12'd0;
        r.return_due_us      = ret ? now + rdelay * 32'd1000 : 32'd0;
        r.return_target      = ret ? 4'(UNIT_ID) : 4'd0;
        r.is_active          = act_on;
        return r;
    endfunction

    // response with no return event, for rows whose result is obvious
    function automatic ndas_pkg::result_t plain_drive(input logic dv, input logic ang,
                                                      input logic [11:0] val,
                                                      input logic on);
        ndas_pkg::result_t r;
        r = '0;
        r.drive_valid    = dv;
        r.drive_is_angle = ang;
        r.drive_value    = val;
        r.is_active      = on;
        return r;
    endfunction

    task automatic add_write(input ndas_pkg::reg_index_t idx, input logic [15:0] val);
        stim_row_t row;
        row.is_write = 1'b1;
        row.idx      = idx;
        row.wval     = val;
        row.cmd      = '0;
        row.vel      = '0;
        row.lvl      = '0;
        row.now      = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        script.push_back(row);
    endtask

    task automatic add_note(input logic [2:0] cmd, input logic [6:0] vel,
                            input logic [11:0] lvl, input logic [31:0] now);
        stim_row_t row;
        row.is_write = 1'b0;
        row.idx      = ndas_pkg::REG_ENABLED;
        row.wval     = '0;
        row.cmd      = cmd;
        row.vel      = vel;
        row.lvl      = lvl;
        row.now      = now;
        row.typed    = 1'b0;
        row.want     = '0;
        script.push_back(row);
    endtask

    task automatic add_typed(input logic [2:0] cmd, input logic [6:0] vel,
            input logic [11:0] lvl, input logic [31:0] now,
            input ndas_pkg::result_t want);
        add_note(cmd, vel, lvl, now);
        script[$].typed = 1'b1;
        script[$].want  = want;
    endtask

    // Register write while idle; called at a clock edge from the driver.
    task automatic write_reg(input ndas_pkg::reg_index_t idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        while (awaited_drives.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ndas_pkg::REG_ENABLED:      sh_enabled = val[0];
            ndas_pkg::REG_MODE:         sh_mode    = val[2:0];
            ndas_pkg::REG_REST_ANGLE:   sh_rest    = val[7:0];
            ndas_pkg::REG_SECOND_ANGLE: sh_second  = val[7:0];
            ndas_pkg::REG_SWING:        sh_swing   = val[7:0];
            ndas_pkg::REG_RETURN_DELAY: sh_delay   = val;
            ndas_pkg::REG_HIT_PWM:      sh_hit     = val[11:0];
            ndas_pkg::REG_HOLD_PWM:     sh_hold    = val[11:0];
            default: ;
        endcase
    endtask

    // Offers one note event and waits until the sequencer accepts it; called at a clock edge.
    task automatic send_note(input logic [2:0] cmd, input logic [6:0] vel,
            input logic [11:0] lvl, input logic [31:0] now,
            input bit typed, input ndas_pkg::result_t want);
        ndas_pkg::result_t pred;
        if (idle_odds > 0 && $urandom_range(0, 7) < idle_odds) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, now, lvl, vel};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        pred = actuator_response(cmd, vel, lvl, now);
        awaited_drives.push_back(typed ? want : pred);
    endtask

    // value biased toward 0, the legal top and the field top
    function automatic logic [15:0] biased_pick(input int top, input int field_top);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'(top);
            2:       return 16'(field_top);
            default: return 16'($urandom_range(0, field_top));
        endcase
    endfunction

    // result checker
    ndas_pkg::result_t mon_got;
    ndas_pkg::result_t mon_want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got.drive_valid        = m_tdata[0];
            mon_got.drive_value        = m_tdata[12:1];
            mon_got.return_valid       = m_tdata[13];
            mon_got.return_level       = m_tdata[25:14];
            mon_got.return_due_us      = m_tdata[57:26];
            mon_got.return_target      = m_tdata[61:58];
            mon_got.is_active          = m_tdata[62];
            mon_got.drive_is_angle     = m_tuser[0];
            mon_got.return_is_position = m_tuser[1];
            if (awaited_drives.size() == 0) begin
                log_error("result transaction with nothing expected");
            end else begin
                mon_want = awaited_drives.pop_front();
                check_field("drive_valid", 32'(mon_got.drive_valid),
                            32'(mon_want.drive_valid));
                check_field("drive_is_angle", 32'(mon_got.drive_is_angle),
                            32'(mon_want.drive_is_angle));
                check_field("drive_value", 32'(mon_got.drive_value),
                            32'(mon_want.drive_value));
                check_field("return_valid", 32'(mon_got.return_valid),
                            32'(mon_want.return_valid));
                check_field("return_is_position", 32'(mon_got.return_is_position),
                            32'(mon_want.return_is_position));
                check_field("return_level", 32'(mon_got.return_level),
                            32'(mon_want.return_level));
                check_field("return_due_us", mon_got.return_due_us,
                            mon_want.return_due_us);
                check_field("return_target", 32'(mon_got.return_target),
                            32'(mon_want.return_target));
                check_field("is_active", 32'(mon_got.is_active),
                            32'(mon_want.is_active));
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (aresetn && idle_odds > 0 && $urandom_range(0, 7) < idle_odds) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial begin
        int          sent;
        int          burst;
        int          pick;
        logic [15:0] val;
        logic [15:0] mask;
        logic [2:0]  cmd;
        logic [6:0]  vel;
        logic [11:0] lvl;
        logic [31:0] now;

        // after reset: disabled, then reinit to the rest angle
        add_typed(ndas_pkg::CMD_NOTE_ON, 7'd127, 12'd0, 32'd0,
                  plain_drive(1'b0, 1'b1, 12'd0, 1'b0));
        add_typed(ndas_pkg::CMD_REINIT, 7'd0, 12'd0, 32'd5,
                  plain_drive(1'b1, 1'b1, 12'd90, 1'b0));
        // servo strike, time wrap, full and zero velocity, position set, ignored commands
        add_write(ndas_pkg::REG_ENABLED, 16'd1);
        add_write(ndas_pkg::REG_MODE, 16'(ndas_pkg::MODE_SERVO_STRIKE));
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd127, 12'd0, 32'hFFFF_FFFF);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd0, 12'hFFF, 32'd0);
        add_note(ndas_pkg::CMD_POS_SET, 7'd64, 12'd4095, 32'd1000);
        add_note(ndas_pkg::CMD_NOTE_OFF, 7'd10, 12'd0, 32'd2000);
        add_note(CMD_SPARE_LAST, 7'd127, 12'hFFF, 32'd3000);
        // angle saturation above the top
        add_write(ndas_pkg::REG_REST_ANGLE, 16'd255);
        add_write(ndas_pkg::REG_SWING, 16'd255);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd127, 12'd0, 32'hFFFF_0000);
        // scratch: up past the top, down below zero
        add_write(ndas_pkg::REG_MODE, 16'(ndas_pkg::MODE_SERVO_SCRATCH));
        add_write(ndas_pkg::REG_REST_ANGLE, 16'd10);
        add_write(ndas_pkg::REG_SWING, 16'd180);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd127, 12'd0, 32'd100);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd127, 12'd0, 32'd200);
        add_note(ndas_pkg::CMD_POS_SET, 7'd0, 12'd0, 32'd300);
        // alternate between the angle extremes
        add_write(ndas_pkg::REG_MODE, 16'(ndas_pkg::MODE_SERVO_ALT));
        add_write(ndas_pkg::REG_REST_ANGLE, 16'd0);
        add_write(ndas_pkg::REG_SECOND_ANGLE, 16'd180);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd1, 12'd0, 32'd400);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd1, 12'd0, 32'd500);
        // key hold
        add_write(ndas_pkg::REG_MODE, 16'(ndas_pkg::MODE_SERVO_KEYHOLD));
        add_write(ndas_pkg::REG_REST_ANGLE, 16'd180);
        add_write(ndas_pkg::REG_SWING, 16'd255);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd100, 12'd0, 32'd600);
        add_note(ndas_pkg::CMD_NOTE_OFF, 7'd100, 12'd0, 32'd700);
        // solenoid strike: shortest and longest pulse, level set, reinit
        add_write(ndas_pkg::REG_MODE, 16'(ndas_pkg::MODE_SOL_STRIKE));
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd0, 12'd0, 32'd800);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd127, 12'd0, 32'hFFFF_FFFF);
        add_note(ndas_pkg::CMD_PWM_SET, 7'd0, 12'd4095, 32'd900);
        add_typed(ndas_pkg::CMD_REINIT, 7'd0, 12'd0, 32'd0,
                  plain_drive(1'b1, 1'b0, 12'd0, 1'b0));
        // hit and hold with the longest ramp
        add_write(ndas_pkg::REG_MODE, 16'(ndas_pkg::MODE_SOL_HITHOLD));
        add_write(ndas_pkg::REG_RETURN_DELAY, 16'hFFFF);
        add_write(ndas_pkg::REG_HIT_PWM, 16'd0);
        add_write(ndas_pkg::REG_HOLD_PWM, 16'd4095);
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd50, 12'd0, 32'hFFFF_FFFF);
        add_note(ndas_pkg::CMD_PWM_SET, 7'd0, 12'd123, 32'd10);
        add_note(ndas_pkg::CMD_NOTE_OFF, 7'd0, 12'd0, 32'd20);
        // spare modes drive nothing; disabled ignores all but reinit
        add_write(ndas_pkg::REG_MODE, 16'(MODE_SPARE_A));
        add_note(ndas_pkg::CMD_NOTE_ON, 7'd127, 12'd0, 32'd30);
        add_write(ndas_pkg::REG_MODE, 16'(MODE_SPARE_B));
        add_write(ndas_pkg::REG_ENABLED, 16'd0);
        add_note(ndas_pkg::CMD_PWM_SET, 7'd127, 12'd77, 32'd40);
        add_note(ndas_pkg::CMD_REINIT, 7'd127, 12'hFFF, 32'hFFFF_FFFF);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        idle_odds = 2;
        foreach (script[i]) begin
            if (script[i].is_write)
                write_reg(script[i].idx, script[i].wval);
            else
                send_note(script[i].cmd, script[i].vel, script[i].lvl, script[i].now,
                          script[i].typed, script[i].want);
        end

        // random part: phases of random settings and random note events
        sent = 0;
        while (sent < RANDOM_NOTES) begin
            for (int i = 0; i < 8; i++) begin
                if (i > int'(ndas_pkg::REG_MODE) && $urandom_range(0, 1) == 0) continue;
                case (ndas_pkg::reg_index_t'(i))
                    ndas_pkg::REG_ENABLED: begin
                        val = 16'($urandom_range(0, 99) < 85);
                        mask = 16'h0001;
                    end
                    ndas_pkg::REG_MODE: begin
                        val = 16'($urandom_range(0, 7));
                        if (val > 16'(ndas_pkg::MODE_SOL_HITHOLD) &&
                            $urandom_range(0, 1) == 1)
                            val = 16'($urandom_range(0, 5));
                        mask = 16'h0007;
                    end
                    ndas_pkg::REG_RETURN_DELAY: begin
                        val = ($urandom_range(0, 3) == 0) ? biased_pick(65535, 65535)
                                                          : 16'($urandom_range(0, 200));
                        mask = 16'hFFFF;
                    end
                    ndas_pkg::REG_HIT_PWM, ndas_pkg::REG_HOLD_PWM: begin
                        val = biased_pick(4095, 4095);
                        mask = 16'h0FFF;
                    end
                    default: begin
                        val = biased_pick(180, 255);
                        mask = 16'h00FF;
                    end
                endcase
                // stray upper bits must be dropped by the register file
                if ($urandom_range(0, 3) == 0)
                    val = val | (16'($urandom) & ~mask);
                write_reg(ndas_pkg::reg_index_t'(i), val);
            end

            burst = $urandom_range(20, 60);
            idle_odds = $urandom_range(0, 3);
            for (int k = 0; k < burst && sent < RANDOM_NOTES; k++) begin
                if (sent >= RANDOM_NOTES - QUIET_TAIL) idle_odds = 0;
                if (sent == HOLD_AT) hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 40)      cmd = ndas_pkg::CMD_NOTE_ON;
                else if (pick < 55) cmd = ndas_pkg::CMD_NOTE_OFF;
                else if (pick < 70) cmd = ndas_pkg::CMD_POS_SET;
                else if (pick < 85) cmd = ndas_pkg::CMD_PWM_SET;
                else if (pick < 90) cmd = ndas_pkg::CMD_REINIT;
                else                cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                if ($urandom_range(0, 3) == 0)
                    vel = $urandom_range(0, 1) ? 7'd127 : 7'd0;
                else
                    vel = 7'($urandom_range(0, 127));
                lvl = ($urandom_range(0, 1) == 1) ? 12'($urandom_range(0, 200))
                                                  : 12'($urandom);
                now = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 100000)
                                                  : $urandom;
                send_note(cmd, vel, lvl, now, 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // drain, then give the pipeline time to show any extra transaction
        while (awaited_drives.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
